// File: sv/irpd_pkg.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// irpd_pkg
// Shared types and codes for the IR pulse-distance decoder.
// ---------------------------------------------------------------------------
package irpd_pkg;

    localparam int FIELD_W = 16;
    localparam int COUNT_W = 8;
    localparam int CFG_IDX_W = 3;

    // input item kinds
    typedef enum logic [1:0] {
        KIND_TICK  = 2'd0,
        KIND_EDGE  = 2'd1,
        KIND_FLUSH = 2'd2,
        KIND_NONE  = 2'd3
    } in_kind_t;

    // result kinds
    typedef enum logic [1:0] {
        RES_WORD    = 2'd0,
        RES_ERROR   = 2'd1,
        RES_PARTIAL = 2'd2
    } res_kind_t;

    // configuration register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_MIN_ONE    = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_MAX_ONE    = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_MIN_ZERO   = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_MAX_ZERO   = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_MARK_LEVEL = 3'd4;

    typedef struct packed {
        res_kind_t            kind;
        logic [FIELD_W-1:0]   word_value;
        logic [COUNT_W-1:0]   word_number;
        logic [FIELD_W-1:0]   error_bit_number;
        logic [FIELD_W-1:0]   error_ticks;
        logic [COUNT_W-1:0]   error_number;
    } result_t;

endpackage

// File: sv/ir_pulse_distance_decoder_unit.sv
`timescale 1ns / 1ps
// Results are registered in the output register, or in the skid register
// while m_* is held. One input beat per cycle while the skid is empty; one
// decode pass over state registers feeds the output reg and one-entry skid.
// Reset (aresetn low, synchronous): config registers, decoder state and
// output valids clear to zero.
// ---------------------------------------------------------------------------
// ir_pulse_distance_decoder_unit
// Infrared pulse-distance decoder: tick counting, window classification,
// word assembly, error records and flush.
// ---------------------------------------------------------------------------
module ir_pulse_distance_decoder_unit
    import irpd_pkg::*;
#(
    parameter int WORD_BITS = 16
) (
    input  logic                  aclk,
    input  logic                  aresetn,

    input  logic                  cfg_valid,
    output logic                  cfg_ready,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [FIELD_W-1:0]    cfg_data,

    input  logic                  s_valid,
    output logic                  s_ready,
    input  logic [1:0]            s_kind,
    input  logic                  s_level,

    output logic                  m_valid,
    input  logic                  m_ready,
    output logic [1:0]            m_result_kind,
    output logic [FIELD_W-1:0]    m_word_value,
    output logic [COUNT_W-1:0]    m_word_number,
    output logic [FIELD_W-1:0]    m_error_bit_number,
    output logic [FIELD_W-1:0]    m_error_ticks,
    output logic [COUNT_W-1:0]    m_error_number
);

    localparam int PW = $clog2(WORD_BITS);
    localparam int EXT_W = (WORD_BITS > FIELD_W) ? WORD_BITS : FIELD_W;
    localparam logic [PW-1:0] LAST_POS = PW'(WORD_BITS - 1);

    // configuration
    logic [FIELD_W-1:0] min_one_reg, max_one_reg, min_zero_reg, max_zero_reg;
    logic               mark_level_reg;

    // decoder state
    logic [FIELD_W-1:0]   tick_count_reg,    tick_count_next;
    logic [PW-1:0]        bit_position_reg,  bit_position_next;
    logic [WORD_BITS-1:0] word_accum_reg,    word_accum_next;
    logic [COUNT_W-1:0]   word_counter_reg,  word_counter_next;
    logic [FIELD_W-1:0]   total_bits_reg,    total_bits_next;
    logic [COUNT_W-1:0]   error_counter_reg, error_counter_next;

    // output stage
    logic    out_valid_reg, skid_valid_reg;
    result_t out_reg, skid_reg;

    result_t            res;
    logic               res_valid;
    logic               accept;
    logic               is_one, is_zero;
    logic [PW-1:0]      shift;
    logic [EXT_W-1:0]   accum_ext;
    logic [FIELD_W-1:0] accum_low;

    assign cfg_ready = 1'b1;
    assign s_ready   = !skid_valid_reg;
    assign accept    = s_valid && s_ready;

    assign accum_ext = EXT_W'(word_accum_reg);
    assign accum_low = accum_ext[FIELD_W-1:0];

    assign is_one  = (tick_count_reg >= min_one_reg) && (tick_count_reg <= max_one_reg);
    assign is_zero = (tick_count_reg >= min_zero_reg) && (tick_count_reg <= max_zero_reg);
    assign shift   = LAST_POS - bit_position_reg;

    always_comb begin
        tick_count_next    = tick_count_reg;
        bit_position_next  = bit_position_reg;
        word_accum_next    = word_accum_reg;
        word_counter_next  = word_counter_reg;
        total_bits_next    = total_bits_reg;
        error_counter_next = error_counter_reg;
        res_valid          = 1'b0;
        res                = '0;

        case (in_kind_t'(s_kind))
            KIND_TICK: begin
                if (tick_count_reg != '1) begin
                    tick_count_next = tick_count_reg + 1'b1;
                end
            end
            KIND_FLUSH: begin
                res_valid          = 1'b1;
                res.kind           = RES_PARTIAL;
                res.word_value     = accum_low;
                res.word_number    = word_counter_reg;
                tick_count_next    = '0;
                bit_position_next  = '0;
                word_accum_next    = '0;
                word_counter_next  = '0;
                total_bits_next    = '0;
                error_counter_next = '0;
            end
            KIND_EDGE: begin
                tick_count_next = '0;
                if (s_level == mark_level_reg) begin
                    // out-of-window durations still count as a one
                    if (is_one || !is_zero) begin
                        word_accum_next = word_accum_reg
                                        | (WORD_BITS'(1) << shift);
                    end
                    if (!is_one && !is_zero) begin
                        res_valid            = 1'b1;
                        res.kind             = RES_ERROR;
                        res.error_bit_number = total_bits_reg;
                        res.error_ticks      = tick_count_reg;
                        res.error_number     = error_counter_reg;
                        error_counter_next   = error_counter_reg + 1'b1;
                    end
                end else begin
                    total_bits_next = total_bits_reg + 1'b1;
                    if (bit_position_reg == LAST_POS) begin
                        res_valid         = 1'b1;
                        res.kind          = RES_WORD;
                        res.word_value    = accum_low;
                        res.word_number   = word_counter_reg;
                        word_counter_next = word_counter_reg + 1'b1;
                        bit_position_next = '0;
                        word_accum_next   = '0;
                    end else begin
                        bit_position_next = bit_position_reg + 1'b1;
                    end
                end
            end
            default: begin
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            min_one_reg    <= '0;
            max_one_reg    <= '0;
            min_zero_reg   <= '0;
            max_zero_reg   <= '0;
            mark_level_reg <= 1'b0;
        end else if (cfg_valid && cfg_ready) begin
            case (cfg_index)
                CFG_MIN_ONE:    min_one_reg    <= cfg_data;
                CFG_MAX_ONE:    max_one_reg    <= cfg_data;
                CFG_MIN_ZERO:   min_zero_reg   <= cfg_data;
                CFG_MAX_ZERO:   max_zero_reg   <= cfg_data;
                CFG_MARK_LEVEL: mark_level_reg <= cfg_data[0];
                default: begin
                end
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            tick_count_reg    <= '0;
            bit_position_reg  <= '0;
            word_accum_reg    <= '0;
            word_counter_reg  <= '0;
            total_bits_reg    <= '0;
            error_counter_reg <= '0;
        end else if (accept) begin
            tick_count_reg    <= tick_count_next;
            bit_position_reg  <= bit_position_next;
            word_accum_reg    <= word_accum_next;
            word_counter_reg  <= word_counter_next;
            total_bits_reg    <= total_bits_next;
            error_counter_reg <= error_counter_next;
        end
    end

    // output register with skid: s_ready only drops when the skid is full
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg  <= 1'b0;
            skid_valid_reg <= 1'b0;
        end else if (skid_valid_reg) begin
            if (m_ready) begin
                out_reg        <= skid_reg;
                skid_valid_reg <= 1'b0;
            end
        end else if (!out_valid_reg || m_ready) begin
            out_valid_reg <= accept && res_valid;
            if (accept && res_valid) begin
                out_reg <= res;
            end
        end else if (accept && res_valid) begin
            skid_reg       <= res;
            skid_valid_reg <= 1'b1;
        end
    end

    assign m_valid            = out_valid_reg;
    assign m_result_kind      = out_reg.kind;
    assign m_word_value       = out_reg.word_value;
    assign m_word_number      = out_reg.word_number;
    assign m_error_bit_number = out_reg.error_bit_number;
    assign m_error_ticks      = out_reg.error_ticks;
    assign m_error_number     = out_reg.error_number;

endmodule

// File: dv/ir_pulse_distance_decoder_unit_test.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// ir_pulse_distance_decoder_unit_test
// Self-checking bench for the IR pulse-distance decoder. A local decode model
// follows every accepted tick, edge and flush beat and queues the records it
// expects; each record on m_* is checked field by field against the oldest
// one. Directed tests cover reset settings, window rules and error counter
// wrap; random frames with noise and flushes follow.
// ---------------------------------------------------------------------------
module ir_pulse_distance_decoder_unit_test
    import irpd_pkg::*;
;

    localparam int WORD_BITS   = 16;
    localparam int QUIET_LIMIT = 2000;

    logic                 aclk      = 1'b0;
    logic                 aresetn   = 1'b0;
    logic                 cfg_valid = 1'b0;
    logic                 cfg_ready;
    logic [CFG_IDX_W-1:0] cfg_index = '0;
    logic [FIELD_W-1:0]   cfg_data  = '0;
    logic                 s_valid   = 1'b0;
    logic                 s_ready;
    logic [1:0]           s_kind    = 2'd0;
    logic                 s_level   = 1'b0;
    logic                 m_valid;
    logic                 m_ready   = 1'b0;
    logic [1:0]           m_result_kind;
    logic [FIELD_W-1:0]   m_word_value;
    logic [COUNT_W-1:0]   m_word_number;
    logic [FIELD_W-1:0]   m_error_bit_number;
    logic [FIELD_W-1:0]   m_error_ticks;
    logic [COUNT_W-1:0]   m_error_number;

    // decoder copy: registers and state
    logic [15:0]          one_min = '0, one_max = '0, zero_min = '0, zero_max = '0;
    logic                 mark_pin_level = 1'b0;
    logic [15:0]          tick_count = '0;
    int unsigned          bit_position = 0;
    logic [WORD_BITS-1:0] word_accum = '0;
    logic [7:0]           word_counter = '0;
    logic [15:0]          total_bits = '0;
    logic [7:0]           error_counter = '0;

    result_t              pending_records[$];
    int unsigned          events_sent = 0;
    int unsigned          mismatch_count = 0;
    int unsigned          quiet_cycles = 0;
    bit                   stall_free = 1'b0;

    ir_pulse_distance_decoder_unit #(.WORD_BITS(WORD_BITS)) u_top (
        .aclk               (aclk),
        .aresetn            (aresetn),
        .cfg_valid          (cfg_valid),
        .cfg_ready          (cfg_ready),
        .cfg_index          (cfg_index),
        .cfg_data           (cfg_data),
        .s_valid            (s_valid),
        .s_ready            (s_ready),
        .s_kind             (s_kind),
        .s_level            (s_level),
        .m_valid            (m_valid),
        .m_ready            (m_ready),
        .m_result_kind      (m_result_kind),
        .m_word_value       (m_word_value),
        .m_word_number      (m_word_number),
        .m_error_bit_number (m_error_bit_number),
        .m_error_ticks      (m_error_ticks),
        .m_error_number     (m_error_number)
    );

    always begin
        #5 aclk = 1'b1;
        #5 aclk = 1'b0;
    end

    function automatic void clear_decoder();
        tick_count    = '0;
        bit_position  = 0;
        word_accum    = '0;
        word_counter  = '0;
        total_bits    = '0;
        error_counter = '0;
    endfunction

    function automatic void write_register(logic [CFG_IDX_W-1:0] index, logic [15:0] data);
        case (index)
            CFG_MIN_ONE:    one_min = data;
            CFG_MAX_ONE:    one_max = data;
            CFG_MIN_ZERO:   zero_min = data;
            CFG_MAX_ZERO:   zero_max = data;
            CFG_MARK_LEVEL: mark_pin_level = data[0];
            default: ;
        endcase
    endfunction

    function automatic void decode_event(in_kind_t kind, logic level);
        result_t rec;
        logic    hit_one;
        logic    hit_zero;
        rec = '0;
        case (kind)
            KIND_TICK: begin
                if (tick_count != 16'hFFFF)
                    tick_count = tick_count + 16'd1;
            end
            KIND_FLUSH: begin
                rec.kind        = RES_PARTIAL;
                rec.word_value  = word_accum[15:0];
                rec.word_number = word_counter;
                pending_records.push_back(rec);
                clear_decoder();
            end
            KIND_EDGE: begin
                if (level == mark_pin_level) begin
                    hit_one  = (tick_count >= one_min) && (tick_count <= one_max);
                    hit_zero = (tick_count >= zero_min) && (tick_count <= zero_max);
                    // the one window wins; a miss on both still counts as a one
                    if (hit_one || !hit_zero)
                        word_accum[WORD_BITS-1-bit_position] = 1'b1;
                    if (!hit_one && !hit_zero) begin
                        rec.kind             = RES_ERROR;
                        rec.error_bit_number = total_bits;
                        rec.error_ticks      = tick_count;
                        rec.error_number     = error_counter;
                        pending_records.push_back(rec);
                        error_counter = error_counter + 8'd1;
                    end
                    tick_count = '0;
                end else begin
                    tick_count   = '0;
                    total_bits   = total_bits + 16'd1;
                    bit_position = bit_position + 1;
                    if (bit_position >= WORD_BITS) begin
                        rec.kind        = RES_WORD;
                        rec.word_value  = word_accum[15:0];
                        rec.word_number = word_counter;
                        pending_records.push_back(rec);
                        word_counter = word_counter + 8'd1;
                        bit_position = 0;
                        word_accum   = '0;
                    end
                end
            end
            default: ;
        endcase
    endfunction

    function automatic void check_field(string name, logic [15:0] want, logic [15:0] got);
        if (got !== want) begin
            $error("%s: expected %0h, actual %0h", name, want, got);
            mismatch_count++;
        end
    endfunction

    // result check first, then config and input beats of the same edge
    always @(posedge aclk) begin
        result_t want;
        if (aresetn) begin
            if (m_valid && m_ready) begin
                if (pending_records.size() == 0) begin
                    $error("unexpected record: kind %0d word %0h", m_result_kind, m_word_value);
                    mismatch_count++;
                end else begin
                    want = pending_records.pop_front();
                    check_field("result_kind", {14'd0, want.kind}, {14'd0, m_result_kind});
                    check_field("word_value", want.word_value, m_word_value);
                    check_field("word_number", {8'd0, want.word_number}, {8'd0, m_word_number});
                    check_field("error_bit_number", want.error_bit_number, m_error_bit_number);
                    check_field("error_ticks", want.error_ticks, m_error_ticks);
                    check_field("error_number", {8'd0, want.error_number},
                                {8'd0, m_error_number});
                end
            end
            if (cfg_valid && cfg_ready)
                write_register(cfg_index, cfg_data);
            if (s_valid && s_ready)
                decode_event(in_kind_t'(s_kind), s_level);
        end
    end

    always @(posedge aclk) begin
        m_ready <= stall_free ? 1'b1 : ($urandom_range(0, 99) >= 17);
    end

    always @(posedge aclk) begin
        if ((s_valid && s_ready) || (m_valid && m_ready) || (cfg_valid && cfg_ready)) begin
            quiet_cycles <= 0;
        end else if (quiet_cycles == QUIET_LIMIT) begin
            $display("** ir_pulse_distance_decoder_unit: FAILED **");
            $finish;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
    end

    task automatic send_event(input in_kind_t kind, input logic level);
        while (!stall_free && $urandom_range(0, 99) < 17) begin
            s_valid <= 1'b0;
            @(posedge aclk);
        end
        s_valid <= 1'b1;
        s_kind  <= kind;
        s_level <= level;
        do @(posedge aclk); while (!s_ready);
        events_sent++;
    endtask

    task automatic send_ticks(input int unsigned count);
        for (int unsigned i = 0; i < count; i++)
            send_event(KIND_TICK, logic'($urandom_range(0, 1)));
    endtask

    // space duration, mark edge, short mark, space edge
    task automatic send_bit(input int unsigned ticks, input logic mark);
        send_ticks(ticks);
        send_event(KIND_EDGE, mark);
        send_ticks($urandom_range(0, 3));
        send_event(KIND_EDGE, !mark);
    endtask

    // stop sending and let every queued record drain
    task automatic settle();
        s_valid <= 1'b0;
        @(posedge aclk);
        while (pending_records.size() != 0)
            @(posedge aclk);
        repeat (4) @(posedge aclk);
    endtask

    task automatic program_decoder(input logic [15:0] min1, input logic [15:0] max1,
                                   input logic [15:0] min0, input logic [15:0] max0,
                                   input logic mark);
        logic [CFG_IDX_W-1:0] idx[5];
        logic [FIELD_W-1:0]   val[5];
        settle();
        idx = '{CFG_MIN_ONE, CFG_MAX_ONE, CFG_MIN_ZERO, CFG_MAX_ZERO, CFG_MARK_LEVEL};
        val = '{min1, max1, min0, max0, {15'd0, mark}};
        for (int i = 0; i < 5; i++) begin
            cfg_valid <= 1'b1;
            cfg_index <= idx[i];
            cfg_data  <= val[i];
            do @(posedge aclk); while (!cfg_ready);
        end
        cfg_valid <= 1'b0;
    endtask

    // registers still at reset: both windows are [0,0], mark is level 0
    task automatic test_reset_config();
        send_event(KIND_EDGE, 1'b0);
        send_ticks(1);
        send_event(KIND_EDGE, 1'b0);
        send_event(KIND_EDGE, 1'b1);
        send_event(KIND_NONE, 1'b1);
        send_event(KIND_NONE, 1'b0);
        send_event(KIND_FLUSH, 1'b1);
    endtask

    task automatic test_window_rules();
        // overlap goes to one, then a plain zero, then a miss
        program_decoder(16'd2, 16'd10, 16'd5, 16'd20, 1'b1);
        send_bit(7, 1'b1);
        send_bit(15, 1'b1);
        send_bit(25, 1'b1);
        send_event(KIND_FLUSH, 1'b0);
        // zero window over 0x0000..0xFFFE and a one window that only takes 0xFFFF
        program_decoder(16'hFFFF, 16'hFFFF, 16'h0000, 16'hFFFE, 1'b0);
        send_bit(3, 1'b0);
        send_bit(0, 1'b0);
        // both windows empty: every mark edge misses
        program_decoder(16'h8000, 16'h7FFF, 16'hFFFF, 16'h0000, 1'b1);
        send_bit(2, 1'b1);
        send_bit(0, 1'b1);
        send_event(KIND_FLUSH, 1'b1);
    endtask

    // error_counter past 8 bits: both windows empty, every mark edge misses
    task automatic test_counter_wrap();
        program_decoder(16'hFFFF, 16'h0000, 16'hFFFF, 16'h0000, 1'b1);
        stall_free = 1'b1;
        send_event(KIND_FLUSH, 1'b0);
        for (int unsigned i = 0; i < 260; i++)
            send_event(KIND_EDGE, 1'b1);
        send_event(KIND_FLUSH, 1'b1);
        settle();
        stall_free = 1'b0;
    endtask

    task automatic test_random_frames();
        int unsigned first_event;
        int          pick;
        logic [15:0] z_lo, z_hi, o_lo, o_hi;
        logic        mark;
        for (int phase = 0; phase < 3; phase++) begin
            z_lo = 16'($urandom_range(0, 3));
            z_hi = z_lo + 16'($urandom_range(0, 3));
            o_lo = ($urandom_range(0, 3) == 0) ? z_lo + 16'($urandom_range(0, 2))
                                               : z_hi + 16'd1 + 16'($urandom_range(0, 2));
            o_hi = z_hi + 16'd1 + 16'($urandom_range(0, 4));
            mark = 1'($urandom_range(0, 1));
            program_decoder(o_lo, o_hi, z_lo, z_hi, mark);
            stall_free   = (phase == 1);
            first_event  = events_sent;
            while (events_sent - first_event < 200) begin
                pick = int'($urandom_range(0, 99));
                if (pick < 85) begin
                    case ($urandom_range(0, 9))
                        0:       send_bit(o_hi + 1 + $urandom_range(0, 3), mark);
                        1, 2, 3, 4: send_bit($urandom_range(z_lo, z_hi), mark);
                        default: send_bit($urandom_range(o_lo, o_hi), mark);
                    endcase
                end else if (pick < 92) begin
                    send_event(in_kind_t'($urandom_range(0, 3)), logic'($urandom_range(0, 1)));
                end else if (pick < 96) begin
                    send_event(KIND_FLUSH, logic'($urandom_range(0, 1)));
                end else begin
                    // stray edge: doubled mark or missing mark
                    send_event(KIND_EDGE, logic'($urandom_range(0, 1)));
                end
            end
            settle();
        end
        stall_free = 1'b0;
    endtask

    initial begin
        repeat (5) @(posedge aclk);
        aresetn <= 1'b1;
        test_reset_config();
        test_window_rules();
        test_counter_wrap();
        test_random_frames();
        settle();
        repeat (8) @(posedge aclk);
        if (mismatch_count == 0 && pending_records.size() == 0)
            $display("** ir_pulse_distance_decoder_unit: PASSED **");
        else
            $display("** ir_pulse_distance_decoder_unit: FAILED **");
        $finish;
    end

endmodule
